// ===== rtl/tsqa_pkg.sv =====
// shared types, constants and helpers for the touch sample qualify and average unit
package tsqa_pkg;

   localparam int RAW_W     = 16;
   localparam int RAW_SHIFT = 3;
   localparam int VAL_W     = RAW_W - RAW_SHIFT;
   localparam int SIZE_W    = 16;
   localparam int PROD_W    = 2 * SIZE_W;
   localparam int WIDE_W    = 2 * PROD_W;
   localparam int CNT_W     = 4;

   localparam int ADC_BITS        = 12;
   localparam int ADC_FULL        = 4095;
   localparam int EDGE_MARGIN     = 50;
   localparam int PRESSURE_OFFSET = ADC_FULL + 1;
   localparam int RECIP_SHIFT     = 40;

   localparam logic [VAL_W-1:0] EDGE_LO = VAL_W'(EDGE_MARGIN);
   localparam logic [VAL_W-1:0] EDGE_HI = VAL_W'(ADC_FULL - EDGE_MARGIN);

   localparam int SAMPLES_PER_FRAME = 5;
   localparam int NEED_RAW          = (SAMPLES_PER_FRAME == 1) ? 1 : SAMPLES_PER_FRAME / 2;
   localparam int NEED_KEPT         = (NEED_RAW == 0) ? 1 : NEED_RAW;

   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = ADDR_W - 2;

   localparam logic [SIZE_W-1:0] RESET_SCREEN_WIDTH  = SIZE_W'(320);
   localparam logic [SIZE_W-1:0] RESET_SCREEN_HEIGHT = SIZE_W'(240);
   localparam logic [SIZE_W-1:0] RESET_THRESHOLD     = SIZE_W'(100);

   typedef enum logic [IDX_W-1:0] {
      REG_SCREEN_WIDTH       = 3'd0,
      REG_SCREEN_HEIGHT      = 3'd1,
      REG_PRESSURE_THRESHOLD = 3'd2,
      REG_USE_TOUCH_PIN      = 3'd3,
      REG_ACTIVE_PIN_LEVEL   = 3'd4
   } reg_index_type;

   typedef enum logic {
      OP_PRESSURE = 1'b0,
      OP_POSITION = 1'b1
   } opcode_type;

   typedef enum logic {
      SEL_AVG_X = 1'b0,
      SEL_AVG_Y = 1'b1
   } div_sel_type;

   typedef struct packed {
      logic [SIZE_W-1:0] screen_width;
      logic [SIZE_W-1:0] screen_height;
      logic [SIZE_W-1:0] pressure_threshold;
      logic              use_touch_pin;
      logic              active_pin_level;
   } cfg_type;

   typedef struct packed {
      logic        ready;
      logic        take;
      logic        div_start;
      logic        div_capture;
      logic        mul;
      logic        scale;
      logic        emit;
      div_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic out_free;
      logic div_busy;
      logic div_done;
   } status_type;

   function automatic logic in_margin(input logic [VAL_W-1:0] v);
      return (v >= EDGE_LO) && (v <= EDGE_HI);
   endfunction

   // divide by the full-scale code through a shift-and-add reciprocal, exact below 2^28
   function automatic logic [SIZE_W-1:0] div_adc_full(input logic [PROD_W-1:0] p);
      logic [WIDE_W-1:0] w;
      logic [WIDE_W-1:0] acc;
      w   = WIDE_W'(p);
      acc = (w << (RECIP_SHIFT - ADC_BITS)) + (w << (RECIP_SHIFT - 2 * ADC_BITS))
            + (w << (RECIP_SHIFT - 3 * ADC_BITS)) + w;
      return SIZE_W'(acc >> RECIP_SHIFT);
   endfunction

endpackage

// ===== rtl/tsqa_req_if.sv =====
// input channel carrying one reading word
interface tsqa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [tsqa_pkg::RAW_W-1:0]    raw_first;
   logic [tsqa_pkg::RAW_W-1:0]    raw_second;
   logic                          pin_level;

   modport source (output valid, opcode, raw_first, raw_second, pin_level, input ready);
   modport sink (input valid, opcode, raw_first, raw_second, pin_level, output ready);
endinterface

// ===== rtl/tsqa_rsp_if.sv =====
// result channel carrying one touch point word
interface tsqa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          touched;
   logic [tsqa_pkg::SIZE_W-1:0]   point_x;
   logic [tsqa_pkg::SIZE_W-1:0]   point_y;
   logic [tsqa_pkg::SIZE_W-1:0]   strength;

   modport source (output valid, touched, point_x, point_y, strength, input ready);
   modport sink (input valid, touched, point_x, point_y, strength, output ready);
endinterface

// ===== rtl/tsqa_csr.sv =====
// configuration registers behind the apb-style port
module tsqa_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tsqa_pkg::ADDR_W-1:0]   paddr,
   input  logic [tsqa_pkg::DATA_W-1:0]   pwdata,
   output logic [tsqa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output tsqa_pkg::cfg_type             cfg
);

   logic [tsqa_pkg::SIZE_W-1:0] screen_width_ff;
   logic [tsqa_pkg::SIZE_W-1:0] screen_height_ff;
   logic [tsqa_pkg::SIZE_W-1:0] threshold_ff;
   logic                        use_pin_ff;
   logic                        active_level_ff;
   logic                        wr_en;
   logic [tsqa_pkg::IDX_W-1:0]  idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[tsqa_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= tsqa_pkg::RESET_SCREEN_WIDTH;
         screen_height_ff <= tsqa_pkg::RESET_SCREEN_HEIGHT;
         threshold_ff     <= tsqa_pkg::RESET_THRESHOLD;
         use_pin_ff       <= 1'b0;
         active_level_ff  <= 1'b0;
      end else if (wr_en) begin
         case (idx)
            tsqa_pkg::REG_SCREEN_WIDTH: begin
               screen_width_ff <= pwdata[tsqa_pkg::SIZE_W-1:0];
            end
            tsqa_pkg::REG_SCREEN_HEIGHT: begin
               screen_height_ff <= pwdata[tsqa_pkg::SIZE_W-1:0];
            end
            tsqa_pkg::REG_PRESSURE_THRESHOLD: begin
               threshold_ff <= pwdata[tsqa_pkg::SIZE_W-1:0];
            end
            tsqa_pkg::REG_USE_TOUCH_PIN: begin
               use_pin_ff <= pwdata[0];
            end
            tsqa_pkg::REG_ACTIVE_PIN_LEVEL: begin
               active_level_ff <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         tsqa_pkg::REG_SCREEN_WIDTH: begin
            prdata = tsqa_pkg::DATA_W'(screen_width_ff);
         end
         tsqa_pkg::REG_SCREEN_HEIGHT: begin
            prdata = tsqa_pkg::DATA_W'(screen_height_ff);
         end
         tsqa_pkg::REG_PRESSURE_THRESHOLD: begin
            prdata = tsqa_pkg::DATA_W'(threshold_ff);
         end
         tsqa_pkg::REG_USE_TOUCH_PIN: begin
            prdata = tsqa_pkg::DATA_W'(use_pin_ff);
         end
         tsqa_pkg::REG_ACTIVE_PIN_LEVEL: begin
            prdata = tsqa_pkg::DATA_W'(active_level_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.screen_width       = screen_width_ff;
   assign cfg.screen_height      = screen_height_ff;
   assign cfg.pressure_threshold = threshold_ff;
   assign cfg.use_touch_pin      = use_pin_ff;
   assign cfg.active_pin_level   = active_level_ff;

endmodule

// ===== rtl/tsqa_div.sv =====
// serial restoring divider, one quotient bit per cycle
module tsqa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsqa_pkg::PROD_W-1:0]   dividend,
   input  logic [tsqa_pkg::SIZE_W-1:0]   divisor,
   output logic                          busy,
   output logic                          done,
   output logic [tsqa_pkg::PROD_W-1:0]   quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [tsqa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tsqa_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [tsqa_pkg::PROD_W-1:0]    quo_ff, quo_in;
   logic [tsqa_pkg::SIZE_W-1:0]    dvs_ff, dvs_in;
   logic [tsqa_pkg::SIZE_W:0]      trial;
   logic [tsqa_pkg::SIZE_W:0]      diff;
   logic                           ge;

   assign trial = {rem_ff, quo_ff[tsqa_pkg::PROD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[tsqa_pkg::SIZE_W-1:0] : trial[tsqa_pkg::SIZE_W-1:0];
         quo_in = {quo_ff[tsqa_pkg::PROD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tsqa_pkg::DIV_CNT_W'(tsqa_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/tsqa_datapath.sv =====
// frame accumulation, pressure gate, scaling and result register
module tsqa_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tsqa_pkg::cfg_type      cfg,
   input  tsqa_pkg::cmd_type      cmd,
   output tsqa_pkg::status_type   status,
   tsqa_req_if.sink               req,
   tsqa_rsp_if.source             rsp
);

   logic [tsqa_pkg::VAL_W-1:0]  a;
   logic [tsqa_pkg::VAL_W-1:0]  b;
   logic [tsqa_pkg::RAW_W-1:0]  z;
   logic                        is_pos;
   logic                        press_fail;
   logic                        keep;
   logic                        last;
   logic [tsqa_pkg::CNT_W-1:0]  kept_next;
   logic [tsqa_pkg::CNT_W-1:0]  seen_next;
   logic                        no_touch;
   logic [tsqa_pkg::SIZE_W-1:0] span_w;
   logic [tsqa_pkg::SIZE_W-1:0] span_h;

   logic                        collecting_ff, collecting_in;
   logic [tsqa_pkg::CNT_W-1:0]  seen_ff, seen_in;
   logic [tsqa_pkg::CNT_W-1:0]  kept_ff, kept_in;
   logic [tsqa_pkg::SIZE_W-1:0] x_sum_ff, x_sum_in;
   logic [tsqa_pkg::SIZE_W-1:0] y_sum_ff, y_sum_in;
   logic [tsqa_pkg::SIZE_W-1:0] pressure_ff, pressure_in;
   logic [tsqa_pkg::SIZE_W-1:0] coord_x_ff, coord_x_in;
   logic [tsqa_pkg::SIZE_W-1:0] coord_y_ff, coord_y_in;
   logic [tsqa_pkg::PROD_W-1:0] prod_x_ff, prod_x_in;
   logic [tsqa_pkg::PROD_W-1:0] prod_y_ff, prod_y_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_touched_ff, rsp_touched_in;
   logic [tsqa_pkg::SIZE_W-1:0] rsp_x_ff, rsp_x_in;
   logic [tsqa_pkg::SIZE_W-1:0] rsp_y_ff, rsp_y_in;
   logic [tsqa_pkg::SIZE_W-1:0] rsp_strength_ff, rsp_strength_in;

   logic [tsqa_pkg::PROD_W-1:0] div_dividend;
   logic [tsqa_pkg::SIZE_W-1:0] div_divisor;
   logic                        div_busy;
   logic                        div_done;
   logic [tsqa_pkg::PROD_W-1:0] div_quotient;

   assign a = tsqa_pkg::VAL_W'(req.raw_first >> tsqa_pkg::RAW_SHIFT);
   assign b = tsqa_pkg::VAL_W'(req.raw_second >> tsqa_pkg::RAW_SHIFT);
   assign z = tsqa_pkg::RAW_W'(a) + tsqa_pkg::RAW_W'(tsqa_pkg::PRESSURE_OFFSET)
              - tsqa_pkg::RAW_W'(b);

   assign is_pos     = req.opcode == tsqa_pkg::OP_POSITION;
   assign press_fail = (cfg.use_touch_pin && (req.pin_level != cfg.active_pin_level))
                       || (z < cfg.pressure_threshold);
   assign keep       = tsqa_pkg::in_margin(a) && tsqa_pkg::in_margin(b);
   assign kept_next  = kept_ff + tsqa_pkg::CNT_W'(keep);
   assign seen_next  = seen_ff + 1'b1;
   assign last       = seen_next >= tsqa_pkg::CNT_W'(tsqa_pkg::SAMPLES_PER_FRAME);

   assign no_touch = cmd.take
                     && ((!is_pos && press_fail)
                         || (is_pos && collecting_ff && last
                             && (kept_next < tsqa_pkg::CNT_W'(tsqa_pkg::NEED_KEPT))));

   assign span_w = (cfg.screen_width == '0) ? '0 : cfg.screen_width - 1'b1;
   assign span_h = (cfg.screen_height == '0) ? '0 : cfg.screen_height - 1'b1;

   // frame state
   always_comb begin
      collecting_in = collecting_ff;
      seen_in       = seen_ff;
      kept_in       = kept_ff;
      x_sum_in      = x_sum_ff;
      y_sum_in      = y_sum_ff;
      pressure_in   = pressure_ff;
      if (cmd.take) begin
         if (!is_pos) begin
            collecting_in = !press_fail;
            seen_in       = '0;
            kept_in       = '0;
            x_sum_in      = '0;
            y_sum_in      = '0;
            pressure_in   = z;
         end else if (collecting_ff) begin
            seen_in = seen_next;
            kept_in = kept_next;
            if (keep) begin
               x_sum_in = x_sum_ff + tsqa_pkg::SIZE_W'(a);
               y_sum_in = y_sum_ff + tsqa_pkg::SIZE_W'(b);
            end
            if (last) begin
               collecting_in = 1'b0;
            end
         end
      end
   end

   // divider operands
   always_comb begin
      case (cmd.sel)
         tsqa_pkg::SEL_AVG_X: begin
            div_dividend = tsqa_pkg::PROD_W'(x_sum_ff);
            div_divisor  = tsqa_pkg::SIZE_W'(kept_ff);
         end
         tsqa_pkg::SEL_AVG_Y: begin
            div_dividend = tsqa_pkg::PROD_W'(y_sum_ff);
            div_divisor  = tsqa_pkg::SIZE_W'(kept_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   tsqa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // averages, then scaled coordinates, share the coordinate registers
   always_comb begin
      coord_x_in = coord_x_ff;
      coord_y_in = coord_y_ff;
      prod_x_in  = prod_x_ff;
      prod_y_in  = prod_y_ff;
      if (cmd.div_capture) begin
         case (cmd.sel)
            tsqa_pkg::SEL_AVG_X: begin
               coord_x_in = div_quotient[tsqa_pkg::SIZE_W-1:0];
            end
            tsqa_pkg::SEL_AVG_Y: begin
               coord_y_in = div_quotient[tsqa_pkg::SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (cmd.scale) begin
         coord_x_in = tsqa_pkg::div_adc_full(prod_x_ff);
         coord_y_in = tsqa_pkg::div_adc_full(prod_y_ff);
      end
      if (cmd.mul) begin
         prod_x_in = tsqa_pkg::PROD_W'(coord_x_ff) * tsqa_pkg::PROD_W'(span_w);
         prod_y_in = tsqa_pkg::PROD_W'(coord_y_ff) * tsqa_pkg::PROD_W'(span_h);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_touched_in  = rsp_touched_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_strength_in = rsp_strength_ff;
      if (no_touch) begin
         rsp_valid_in    = 1'b1;
         rsp_touched_in  = 1'b0;
         rsp_x_in        = '0;
         rsp_y_in        = '0;
         rsp_strength_in = '0;
      end else if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_touched_in  = 1'b1;
         rsp_x_in        = coord_x_ff;
         rsp_y_in        = coord_y_ff;
         rsp_strength_in = pressure_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         seen_ff       <= '0;
         kept_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         seen_ff       <= seen_in;
         kept_ff       <= kept_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_sum_ff        <= x_sum_in;
      y_sum_ff        <= y_sum_in;
      pressure_ff     <= pressure_in;
      coord_x_ff      <= coord_x_in;
      coord_y_ff      <= coord_y_in;
      prod_x_ff       <= prod_x_in;
      prod_y_ff       <= prod_y_in;
      rsp_touched_ff  <= rsp_touched_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_strength_ff <= rsp_strength_in;
   end

   assign req.ready = cmd.ready;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.touched  = rsp_touched_ff;
   assign rsp.point_x  = rsp_x_ff;
   assign rsp.point_y  = rsp_y_ff;
   assign rsp.strength = rsp_strength_ff;

   assign status.frame_ok = is_pos && collecting_ff && last
                            && (kept_next >= tsqa_pkg::CNT_W'(tsqa_pkg::NEED_KEPT));
   assign status.out_free = !rsp_valid_ff || rsp.ready;
   assign status.div_busy = div_busy;
   assign status.div_done = div_done;

endmodule

// ===== rtl/tsqa_ctrl.sv =====
// controller sequencing the averaging divisions and the scaling
module tsqa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  tsqa_pkg::status_type   status,
   output tsqa_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_DIV_START = 6'b000010,
      ST_DIV_WAIT  = 6'b000100,
      ST_MUL       = 6'b001000,
      ST_SCALE     = 6'b010000,
      ST_EMIT      = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   tsqa_pkg::div_sel_type sel_ff, sel_in;

   always_comb begin
      state_in        = state_ff;
      sel_in          = sel_ff;
      cmd.ready       = 1'b0;
      cmd.take        = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_capture = 1'b0;
      cmd.mul         = 1'b0;
      cmd.scale       = 1'b0;
      cmd.emit        = 1'b0;
      cmd.sel         = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready = status.out_free;
            cmd.take  = status.out_free && req_valid;
            if (cmd.take && status.frame_ok) begin
               sel_in   = tsqa_pkg::SEL_AVG_X;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               case (sel_ff)
                  tsqa_pkg::SEL_AVG_X: begin
                     sel_in   = tsqa_pkg::SEL_AVG_Y;
                     state_in = ST_DIV_START;
                  end
                  tsqa_pkg::SEL_AVG_Y: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= tsqa_pkg::SEL_AVG_X;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== rtl/touch_sample_qualify_average_unit.sv =====
// top level of the touch sample qualify and average unit
// A pressure word opens a frame and is gated by the touch pin (when enabled) and the
// pressure threshold; a failing gate returns a no-touch word at once. The following
// position words are collected and those inside the edge margin are summed. The
// position word that closes a frame with enough kept samples starts two averaging
// divisions on one serial divider that makes one quotient bit per cycle, then a
// multiply step and a step that scales both axes by a shift-and-add reciprocal of the
// full-scale code; no new word is taken until that result has been emitted. A finished
// result waits in an output register; a new word is taken once that register is
// empty or is being read.
module touch_sample_qualify_average_unit (
   input  logic                          clock,
   input  logic                          reset,
   tsqa_req_if.sink                      req_chan,
   tsqa_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tsqa_pkg::ADDR_W-1:0]   paddr,
   input  logic [tsqa_pkg::DATA_W-1:0]   pwdata,
   output logic [tsqa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   tsqa_pkg::cfg_type    cfg;
   tsqa_pkg::cmd_type    cmd;
   tsqa_pkg::status_type status;

   tsqa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   tsqa_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .req    (req_chan),
      .rsp    (rsp_chan)
   );

   a_ready_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("input taken while result register stays full");

   a_no_input_during_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_chan.ready)
      else $error("input ready while divider busy");

   a_no_touch_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.touched) |->
         (rsp_chan.point_x == '0 && rsp_chan.point_y == '0 && rsp_chan.strength == '0))
      else $error("no-touch word carries nonzero fields");

   a_emit_gives_touch: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_chan.valid && rsp_chan.touched))
      else $error("point emit did not load a touched word");

endmodule
